// ===== rtl/gdf_pkg.sv =====
// Shared types and constants for the gated edge duration ring.
`default_nettype none
package gdf_pkg;

  localparam int unsigned RING_DEPTH = 256;
  localparam int unsigned RING_AW    = $clog2(RING_DEPTH);

  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int unsigned CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  localparam logic [15:0] GAP_MARK = 16'hFFFF;
  localparam logic [15:0] DUR_MAX  = 16'hFFFE;

  typedef enum logic [1:0] {
    ACT_SENSE = 2'd0,
    ACT_EDGE  = 2'd1,
    ACT_POP   = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_GAP  = 2'd1,
    CMD_EDGE = 2'd2,
    CMD_POP  = 2'd3
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [15:0] dur;
    logic        level;
  } cmd_t;

  typedef struct packed {
    logic [15:0] dur;
    logic        level;
  } ring_entry_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_READ = 1'b1
  } back_state_t;

endpackage
`default_nettype wire

// ===== rtl/gdf_if.sv =====
// Handshake interfaces for the input and result channels.
`default_nettype none
interface gdf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] time_us;
  logic        sense_level;
  logic        data_level;

  modport source (output valid, action, time_us, sense_level, data_level, input ready);
  modport sink   (input valid, action, time_us, sense_level, data_level, output ready);
endinterface

interface gdf_out_if;
  logic        valid;
  logic        ready;
  logic        entry_valid;
  logic [15:0] pulse_us;
  logic        pulse_level;
  logic        is_gap;
  logic [31:0] drop_count;

  modport source (output valid, entry_valid, pulse_us, pulse_level, is_gap, drop_count,
                  input ready);
  modport sink   (input valid, entry_valid, pulse_us, pulse_level, is_gap, drop_count,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/gated_edge_duration_fifo.sv =====
// Top level of the carrier-gated pulse-width capture ring.
// A result passes through the command queue and then the result register; a pop that
// finds an entry also passes the ring memory's registered read port.
// Throughput: one item per cycle while results are taken, except that a pop which
// finds an entry also holds the ring engine in BK_READ; a two-entry queue absorbs it.
// Reset (rst_n low, synchronous): ring empty, gate closed, timestamp, level and drop
// count cleared; ring contents are not cleared, so no clearing pass is needed.
`default_nettype none
module gated_edge_duration_fifo (
  input  wire logic clk,
  input  wire logic rst_n,
  gdf_in_if.sink    in_ch,
  gdf_out_if.source out_ch
);

  gdf_pkg::cmd_t front_cmd, back_cmd;
  logic          front_valid, front_ready;
  logic          back_valid, back_ready;

  gdf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd       (front_cmd),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready)
  );

  gdf_cmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_cmd    (front_cmd),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .out_cmd   (back_cmd),
    .out_valid (back_valid),
    .out_ready (back_ready)
  );

  gdf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (back_cmd),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

// ===== rtl/gdf_front.sv =====
// Front end: accepts items, tracks the gate and last edge, and issues ring commands.
`default_nettype none
module gdf_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  gdf_in_if.sink            in_ch,
  output gdf_pkg::cmd_t     cmd,
  output logic              cmd_valid,
  input  wire logic         cmd_ready
);

  logic        gate_r, gate_nxt;
  logic [31:0] last_time_r, last_time_nxt;
  logic        last_level_r, last_level_nxt;
  logic [31:0] diff;
  logic [15:0] dur_clamped;
  logic        accept;

  assign in_ch.ready = cmd_ready;
  assign cmd_valid   = in_ch.valid;
  assign accept      = in_ch.valid && cmd_ready;

  assign diff        = in_ch.time_us - last_time_r;
  assign dur_clamped = (diff > {16'd0, gdf_pkg::DUR_MAX}) ? gdf_pkg::DUR_MAX : diff[15:0];

  always_comb begin
    gate_nxt       = gate_r;
    last_time_nxt  = last_time_r;
    last_level_nxt = last_level_r;
    cmd.op         = gdf_pkg::CMD_NONE;
    cmd.dur        = dur_clamped;
    cmd.level      = last_level_r;
    unique case (gdf_pkg::action_t'(in_ch.action))
      gdf_pkg::ACT_SENSE: begin
        gate_nxt = in_ch.sense_level;
        if (in_ch.sense_level) begin
          last_time_nxt  = in_ch.time_us;
          last_level_nxt = in_ch.data_level;
        end else begin
          cmd.op = gdf_pkg::CMD_GAP;
        end
      end
      gdf_pkg::ACT_EDGE: begin
        if (gate_r) begin
          cmd.op         = gdf_pkg::CMD_EDGE;
          last_time_nxt  = in_ch.time_us;
          last_level_nxt = in_ch.data_level;
        end
      end
      gdf_pkg::ACT_POP: cmd.op = gdf_pkg::CMD_POP;
      default:          cmd.op = gdf_pkg::CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_r       <= 1'b0;
      last_time_r  <= 32'd0;
      last_level_r <= 1'b0;
    end else if (accept) begin
      gate_r       <= gate_nxt;
      last_time_r  <= last_time_nxt;
      last_level_r <= last_level_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/gdf_cmd_queue.sv =====
// Short command queue between the front end and the ring engine.
`default_nettype none
module gdf_cmd_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire gdf_pkg::cmd_t in_cmd,
  input  wire logic          in_valid,
  output logic               in_ready,
  output gdf_pkg::cmd_t      out_cmd,
  output logic               out_valid,
  input  wire logic          out_ready
);

  gdf_pkg::cmd_t                   slot_r [gdf_pkg::CMDQ_DEPTH];
  logic [gdf_pkg::CMDQ_AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [gdf_pkg::CMDQ_CW-1:0]     count_r, count_nxt;
  logic                            push, pop;

  assign in_ready  = (count_r != gdf_pkg::CMDQ_CW'(gdf_pkg::CMDQ_DEPTH));
  assign out_valid = (count_r != '0);
  assign out_cmd   = slot_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == gdf_pkg::CMDQ_AW'(gdf_pkg::CMDQ_DEPTH - 1)) ? '0
                                                                            : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == gdf_pkg::CMDQ_AW'(gdf_pkg::CMDQ_DEPTH - 1)) ? '0
                                                                            : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/gdf_back.sv =====
// Ring engine: holds the duration ring, the drop counter and the result register.
`default_nettype none
module gdf_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire gdf_pkg::cmd_t cmd,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  gdf_out_if.source          out_ch
);

  gdf_pkg::ring_entry_t          ring_mem [gdf_pkg::RING_DEPTH];
  gdf_pkg::ring_entry_t          rd_data_r;
  gdf_pkg::ring_entry_t          wr_data;
  logic                          wr_en, rd_en;

  gdf_pkg::back_state_t          state_r, state_nxt;
  logic [gdf_pkg::RING_AW-1:0]   head_r, head_nxt, tail_r, tail_nxt, head_inc;
  logic [31:0]                   drop_r, drop_nxt;
  logic                          full, empty, take;

  logic                          out_valid_r, out_valid_nxt;
  logic                          entry_valid_r, entry_valid_nxt;
  logic [15:0]                   pulse_us_r, pulse_us_nxt;
  logic                          pulse_level_r, pulse_level_nxt;
  logic                          is_gap_r, is_gap_nxt;
  logic [31:0]                   drop_count_r, drop_count_nxt;
  logic                          load_out;

  function automatic logic [gdf_pkg::RING_AW-1:0] ring_next(
    input logic [gdf_pkg::RING_AW-1:0] ptr
  );
    logic [gdf_pkg::RING_AW-1:0] res;
    if (ptr == gdf_pkg::RING_AW'(gdf_pkg::RING_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = ptr + 1'b1;
    end
    return res;
  endfunction

  assign head_inc = ring_next(head_r);
  assign full     = (head_inc == tail_r);
  assign empty    = (head_r == tail_r);
  assign take     = cmd_valid && cmd_ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.entry_valid = entry_valid_r;
  assign out_ch.pulse_us    = pulse_us_r;
  assign out_ch.pulse_level = pulse_level_r;
  assign out_ch.is_gap      = is_gap_r;
  assign out_ch.drop_count  = drop_count_r;

  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    drop_nxt        = drop_r;
    wr_en           = 1'b0;
    rd_en           = 1'b0;
    wr_data.dur     = cmd.dur;
    wr_data.level   = cmd.level;
    cmd_ready       = 1'b0;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    load_out        = 1'b0;
    entry_valid_nxt = 1'b0;
    pulse_us_nxt    = '0;
    pulse_level_nxt = 1'b0;
    is_gap_nxt      = 1'b0;
    drop_count_nxt  = drop_r;

    unique case (state_r)
      gdf_pkg::BK_IDLE: begin
        cmd_ready = !out_valid_r || out_ch.ready;
        if (take) begin
          unique case (cmd.op)
            gdf_pkg::CMD_NONE: load_out = 1'b1;
            gdf_pkg::CMD_GAP: begin
              load_out = 1'b1;
              // A gap marker that does not fit is dropped without counting.
              if (!full) begin
                wr_en         = 1'b1;
                wr_data.dur   = gdf_pkg::GAP_MARK;
                wr_data.level = 1'b0;
                head_nxt      = head_inc;
              end
            end
            gdf_pkg::CMD_EDGE: begin
              load_out = 1'b1;
              if (!full) begin
                wr_en    = 1'b1;
                head_nxt = head_inc;
              end else begin
                drop_nxt = drop_r + 32'd1;
              end
              drop_count_nxt = drop_nxt;
            end
            gdf_pkg::CMD_POP: begin
              if (empty) begin
                load_out = 1'b1;
              end else begin
                rd_en     = 1'b1;
                tail_nxt  = ring_next(tail_r);
                state_nxt = gdf_pkg::BK_READ;
              end
            end
          endcase
        end
      end
      gdf_pkg::BK_READ: begin
        // The result register was freed when the pop was taken.
        load_out        = 1'b1;
        entry_valid_nxt = 1'b1;
        state_nxt       = gdf_pkg::BK_IDLE;
        if (rd_data_r.dur == gdf_pkg::GAP_MARK) begin
          is_gap_nxt = 1'b1;
        end else begin
          pulse_us_nxt    = rd_data_r.dur;
          pulse_level_nxt = rd_data_r.level;
        end
      end
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gdf_pkg::BK_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      drop_r      <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      entry_valid_r <= entry_valid_nxt;
      pulse_us_r    <= pulse_us_nxt;
      pulse_level_r <= pulse_level_nxt;
      is_gap_r      <= is_gap_nxt;
      drop_count_r  <= drop_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[head_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= ring_mem[tail_r];
    end
  end

endmodule
`default_nettype wire

// ===== bench/gated_edge_duration_fifo_test.sv =====
// Self-checking testbench for the carrier-gated pulse-width capture ring.
`default_nettype none
module gated_edge_duration_fifo_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gdf_pkg::*;

  localparam logic [1:0] ACT_UNUSED  = 2'd3;
  localparam int         EVENT_GOAL  = 1650;
  localparam int         PROBE_COUNT = 22;
  localparam int         LONG_HOLD   = 400;

  typedef struct packed {
    logic        entry_valid;
    logic [15:0] pulse_us;
    logic        pulse_level;
    logic        is_gap;
    logic [31:0] drop_count;
  } pulse_result_t;

  typedef struct packed {
    logic [1:0]    act;
    logic [31:0]   stamp;
    logic          sense;
    logic          data;
    logic          pinned;
    pulse_result_t want;
  } probe_row_t;

  localparam pulse_result_t NO_ENTRY  = '0;
  localparam pulse_result_t GAP_ENTRY = '{1'b1, 16'd0, 1'b0, 1'b1, 32'd0};

  logic clk;
  logic rst_n;

  gdf_in_if  in_ch ();
  gdf_out_if out_ch ();

  gated_edge_duration_fifo dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the block's state, advanced once per accepted item.
  ring_entry_t   shadow_ring [RING_DEPTH];
  int unsigned   shadow_wr;
  int unsigned   shadow_rd;
  logic          shadow_gate;
  logic [31:0]   shadow_stamp;
  logic          shadow_level;
  logic [31:0]   shadow_drops;

  pulse_result_t expected_pulses [$];
  probe_row_t    probe_table [PROBE_COUNT];
  pulse_result_t seen_pulse;
  pulse_result_t oldest_pulse;
  logic [31:0]   clock_us;
  int            error_count;
  int            results_seen;
  int            accepted_events;
  int            send_run_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("gated_edge_duration_fifo_test: errors");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    error_count++;
  endtask

  function automatic int unsigned ring_after(input int unsigned idx);
    return (idx + 1 >= RING_DEPTH) ? 0 : idx + 1;
  endfunction

  function automatic int unsigned ring_fill();
    return (shadow_wr + RING_DEPTH - shadow_rd) % RING_DEPTH;
  endfunction

  function automatic bit ring_push(input ring_entry_t entry);
    if (ring_after(shadow_wr) == shadow_rd) return 1'b0;
    shadow_ring[shadow_wr] = entry;
    shadow_wr = ring_after(shadow_wr);
    return 1'b1;
  endfunction

  function automatic pulse_result_t predict_pulse(input logic [1:0] act,
                                                  input logic [31:0] stamp,
                                                  input logic sense, input logic data);
    pulse_result_t res;
    logic [31:0]   span;
    ring_entry_t   entry;
    res = NO_ENTRY;
    case (act)
      ACT_SENSE: begin
        shadow_gate = sense;
        if (sense) begin
          shadow_stamp = stamp;
          shadow_level = data;
        end else begin
          void'(ring_push('{GAP_MARK, 1'b0}));
        end
      end
      ACT_EDGE: begin
        if (shadow_gate) begin
          span = stamp - shadow_stamp;
          entry.dur   = (span > {16'd0, DUR_MAX}) ? DUR_MAX : span[15:0];
          entry.level = shadow_level;
          if (!ring_push(entry)) shadow_drops = shadow_drops + 32'd1;
          shadow_stamp = stamp;
          shadow_level = data;
        end
      end
      ACT_POP: begin
        if (shadow_rd != shadow_wr) begin
          entry = shadow_ring[shadow_rd];
          shadow_rd = ring_after(shadow_rd);
          res.entry_valid = 1'b1;
          if (entry.dur == GAP_MARK) begin
            res.is_gap = 1'b1;
          end else begin
            res.pulse_us    = entry.dur;
            res.pulse_level = entry.level;
          end
        end
      end
      default: ;
    endcase
    res.drop_count = shadow_drops;
    return res;
  endfunction

  // Mostly back-to-back or short gaps, the odd long one.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int next_send_gap();
    if (send_run_left > 0) begin
      send_run_left--;
      return 0;
    end
    if ($urandom_range(0, 99) < 3) begin
      send_run_left = $urandom_range(30, 80);
      return 0;
    end
    return pick_idle();
  endfunction

  // Timestamps mostly creep forward; some steps land near the clamp, a few jump anywhere.
  function automatic logic [31:0] next_stamp();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)      clock_us = clock_us + $urandom_range(0, 300);
    else if (r < 90) clock_us = clock_us + $urandom_range(300, 70000);
    else if (r < 97) clock_us = clock_us + $urandom_range(65530, 65540);
    else             clock_us = $urandom;
    return clock_us;
  endfunction

  task automatic offer(input logic [1:0] act, input logic [31:0] stamp, input logic sense,
                       input logic data, input logic pinned, input pulse_result_t want);
    int            gap;
    bit            ignored;
    pulse_result_t predicted;
    gap = next_send_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= act;
    in_ch.time_us     <= stamp;
    in_ch.sense_level <= sense;
    in_ch.data_level  <= data;
    do @(posedge clk); while (!in_ch.ready);
    ignored   = (act == ACT_UNUSED) || (act == ACT_EDGE && !shadow_gate);
    predicted = predict_pulse(act, stamp, sense, data);
    expected_pulses.push_back(pinned ? want : predicted);
    if (!ignored) accepted_events++;
  endtask

  task automatic send(input logic [1:0] act, input logic [31:0] stamp, input logic sense,
                      input logic data);
    offer(act, stamp, sense, data, 1'b0, NO_ENTRY);
  endtask

  task automatic send_pop();
    send(ACT_POP, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // One carrier burst: gate opens, a run of edges with pops mixed in, gate closes.
  task automatic gate_burst(input int edges, input int pop_pct);
    send(ACT_SENSE, next_stamp(), 1'b1, 1'($urandom_range(0, 1)));
    repeat (edges) begin
      if ($urandom_range(0, 99) < pop_pct) send_pop();
      send(ACT_EDGE, next_stamp(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
    send(ACT_SENSE, next_stamp(), 1'b0, 1'($urandom_range(0, 1)));
  endtask

  task automatic drain(input int extra);
    while (ring_fill() != 0) send_pop();
    repeat (extra) send_pop();
  endtask

  // Overrun the ring so that edges drop and gap markers are skipped, then empty it.
  task automatic fill_ring(input int pop_pct);
    send(ACT_SENSE, next_stamp(), 1'b1, 1'($urandom_range(0, 1)));
    repeat (RING_DEPTH + 44) begin
      if ($urandom_range(0, 99) < pop_pct) send_pop();
      send(ACT_EDGE, next_stamp(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
    send(ACT_SENSE, next_stamp(), 1'b0, 1'b0);
    send(ACT_SENSE, next_stamp(), 1'b0, 1'b1);
    send(ACT_EDGE, next_stamp(), 1'b1, 1'b1);
    drain(3);
  endtask

  task automatic noise_item();
    send(2'($urandom_range(0, 3)), ($urandom_range(0, 1) == 1) ? $urandom : next_stamp(),
         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic mixed_traffic(input int goal);
    int r;
    while (accepted_events < goal) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        gate_burst($urandom_range(1, 24), $urandom_range(10, 60));
      end else if (r < 90) begin
        repeat ($urandom_range(1, 4)) noise_item();
      end else begin
        drain($urandom_range(0, 2));
      end
    end
  endtask

  // Stimulus and end of run.
  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.action      <= ACT_SENSE;
    in_ch.time_us     <= '0;
    in_ch.sense_level <= 1'b0;
    in_ch.data_level  <= 1'b0;
    shadow_ring       = '{default: '0};
    shadow_wr         = 0;
    shadow_rd         = 0;
    shadow_gate       = 1'b0;
    shadow_stamp      = '0;
    shadow_level      = 1'b0;
    shadow_drops      = '0;
    clock_us          = '0;
    error_count       = 0;
    accepted_events   = 0;
    send_run_left     = 0;

    probe_table = '{
      '{ACT_POP,    32'h0000_0000, 1'b0, 1'b0, 1'b1, NO_ENTRY},  // empty after reset
      '{ACT_EDGE,   32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, NO_ENTRY},  // gate closed: ignored
      '{ACT_UNUSED, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, NO_ENTRY},
      '{ACT_SENSE,  32'h0000_0000, 1'b0, 1'b1, 1'b1, NO_ENTRY},  // close while closed
      '{ACT_POP,    32'h0000_0000, 1'b0, 1'b0, 1'b1, GAP_ENTRY},
      '{ACT_SENSE,  32'hFFFF_FFF0, 1'b1, 1'b1, 1'b1, NO_ENTRY},
      '{ACT_EDGE,   32'h0000_0010, 1'b1, 1'b0, 1'b1, NO_ENTRY},  // timestamp wraps
      '{ACT_EDGE,   32'h0000_0010, 1'b0, 1'b1, 1'b1, NO_ENTRY},  // zero width
      '{ACT_EDGE,   32'h0001_0010, 1'b1, 1'b0, 1'b1, NO_ENTRY},  // past the clamp
      '{ACT_EDGE,   32'h0002_000E, 1'b0, 1'b1, 1'b1, NO_ENTRY},  // exactly the clamp
      '{ACT_EDGE,   32'h0003_000D, 1'b1, 1'b0, 1'b1, NO_ENTRY},  // one over, not a gap
      '{ACT_SENSE,  32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, NO_ENTRY},  // reopen while open
      '{ACT_EDGE,   32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, NO_ENTRY},
      '{ACT_SENSE,  32'h8000_0000, 1'b0, 1'b0, 1'b1, NO_ENTRY},
      '{ACT_POP,    32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, NO_ENTRY},
      '{ACT_POP,    32'h0000_0000, 1'b0, 1'b0, 1'b0, NO_ENTRY},
      '{ACT_POP,    32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, NO_ENTRY},
      '{ACT_POP,    32'h0000_0000, 1'b0, 1'b0, 1'b0, NO_ENTRY},
      '{ACT_POP,    32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, NO_ENTRY},
      '{ACT_POP,    32'h0000_0000, 1'b0, 1'b0, 1'b0, NO_ENTRY},
      '{ACT_POP,    32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, NO_ENTRY},
      '{ACT_POP,    32'h0000_0000, 1'b0, 1'b0, 1'b1, NO_ENTRY}   // empty again
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < PROBE_COUNT; i++) begin
      offer(probe_table[i].act, probe_table[i].stamp, probe_table[i].sense,
            probe_table[i].data, probe_table[i].pinned, probe_table[i].want);
    end

    fill_ring(0);
    mixed_traffic(900);
    fill_ring(3);
    mixed_traffic(EVENT_GOAL);
    in_ch.valid <= 1'b0;

    while (expected_pulses.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("gated_edge_duration_fifo_test: clean");
    end else begin
      $display("gated_edge_duration_fifo_test: errors");
    end
    $finish;
  end

  // Result side: random stalls, plus one long hold-off so the input backs up.
  initial begin
    int stall_left;
    int run_left;
    bit held_long;
    stall_left = 0;
    run_left   = 0;
    held_long  = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held_long && results_seen >= 600) begin
        held_long  = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (run_left > 0) begin
        run_left--;
        out_ch.ready <= 1'b1;
      end else begin
        if ($urandom_range(0, 99) < 4) run_left = $urandom_range(30, 80);
        stall_left = pick_idle();
        out_ch.ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  initial results_seen = 0;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_pulse = {out_ch.entry_valid, out_ch.pulse_us, out_ch.pulse_level,
                    out_ch.is_gap, out_ch.drop_count};
      if (expected_pulses.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing outstanding: %h",
                                  results_seen, seen_pulse));
      end else begin
        oldest_pulse = expected_pulses.pop_front();
        if (seen_pulse.entry_valid !== oldest_pulse.entry_valid)
          report_mismatch($sformatf("result %0d entry_valid got %0b want %0b", results_seen,
                                    seen_pulse.entry_valid, oldest_pulse.entry_valid));
        if (seen_pulse.pulse_us !== oldest_pulse.pulse_us)
          report_mismatch($sformatf("result %0d pulse_us got %0d want %0d", results_seen,
                                    seen_pulse.pulse_us, oldest_pulse.pulse_us));
        if (seen_pulse.pulse_level !== oldest_pulse.pulse_level)
          report_mismatch($sformatf("result %0d pulse_level got %0b want %0b", results_seen,
                                    seen_pulse.pulse_level, oldest_pulse.pulse_level));
        if (seen_pulse.is_gap !== oldest_pulse.is_gap)
          report_mismatch($sformatf("result %0d is_gap got %0b want %0b", results_seen,
                                    seen_pulse.is_gap, oldest_pulse.is_gap));
        if (seen_pulse.drop_count !== oldest_pulse.drop_count)
          report_mismatch($sformatf("result %0d drop_count got %0d want %0d", results_seen,
                                    seen_pulse.drop_count, oldest_pulse.drop_count));
      end
      results_seen <= results_seen + 1;
    end
  end

endmodule
`default_nettype wire

// ===== gated_edge_duration_fifo.f =====
rtl/gdf_pkg.sv
rtl/gdf_if.sv
rtl/gdf_front.sv
rtl/gdf_cmd_queue.sv
rtl/gdf_back.sv
rtl/gated_edge_duration_fifo.sv
bench/gated_edge_duration_fifo_test.sv
